// ===== rtl/rlp3_pkg.sv =====
`timescale 1ns / 1ps

package rlp3_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int COEF_FRAC_BITS   = 28;
  localparam int COEF_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH  = 8;

  // tdata is padded to whole bytes
  localparam int DATA_WIDTH       = ((SAMPLE_WIDTH + 7) / 8) * 8;

  // 1-3-3-1 sum of four samples needs three extra bits
  localparam int BINOM_WIDTH      = SAMPLE_WIDTH + 3;
  localparam int FF_PROD_WIDTH    = COEF_WIDTH + BINOM_WIDTH;
  localparam int FB_PROD_WIDTH    = COEF_WIDTH + SAMPLE_WIDTH;
  // four products summed, plus the rounding constant
  localparam int ACC_WIDTH        = FF_PROD_WIDTH + 3;
  localparam int SHIFT_WIDTH      = ACC_WIDTH - COEF_FRAC_BITS;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN           = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_ONE   = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_TWO   = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_THREE = CFG_INDEX_WIDTH'(3);

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
    {{(ACC_WIDTH-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] gain;
    logic signed [COEF_WIDTH-1:0] fb_one;
    logic signed [COEF_WIDTH-1:0] fb_two;
    logic signed [COEF_WIDTH-1:0] fb_three;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x1;
    logic signed [SAMPLE_WIDTH-1:0] x2;
    logic signed [SAMPLE_WIDTH-1:0] x3;
    logic signed [SAMPLE_WIDTH-1:0] y1;
    logic signed [SAMPLE_WIDTH-1:0] y2;
    logic signed [SAMPLE_WIDTH-1:0] y3;
  } hist_t;

endpackage

// ===== rtl/rlp3_coef_regs.sv =====
`timescale 1ns / 1ps

module rlp3_coef_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [rlp3_pkg::CFG_INDEX_WIDTH-1:0]  wr_index,
  input  logic [rlp3_pkg::COEF_WIDTH-1:0]       wr_data,
  output rlp3_pkg::coef_t                       coef
);

  // out-of-range indexes fall through the default arm and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_en) begin
      case (wr_index)
        rlp3_pkg::REG_GAIN:           coef.gain     <= wr_data;
        rlp3_pkg::REG_FEEDBACK_ONE:   coef.fb_one   <= wr_data;
        rlp3_pkg::REG_FEEDBACK_TWO:   coef.fb_two   <= wr_data;
        rlp3_pkg::REG_FEEDBACK_THREE: coef.fb_three <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rlp3_calc.sv =====
`timescale 1ns / 1ps

module rlp3_calc (
  input  logic signed [rlp3_pkg::SAMPLE_WIDTH-1:0] x,
  input  rlp3_pkg::hist_t                          hist,
  input  rlp3_pkg::coef_t                          coef,
  output logic signed [rlp3_pkg::SAMPLE_WIDTH-1:0] y,
  output logic                                     clip
);

  localparam int BW = rlp3_pkg::BINOM_WIDTH;
  localparam int AW = rlp3_pkg::ACC_WIDTH;
  localparam int SW = rlp3_pkg::SHIFT_WIDTH;
  localparam int NW = rlp3_pkg::SAMPLE_WIDTH;

  logic signed [BW-1:0] xe, x1e, x2e, x3e, binom;
  logic signed [rlp3_pkg::FF_PROD_WIDTH-1:0] p_gain;
  logic signed [rlp3_pkg::FB_PROD_WIDTH-1:0] p_one, p_two, p_three;
  logic signed [AW-1:0] acc;
  logic signed [SW-1:0] shifted;
  logic                 fits;

  always_comb begin
    xe    = BW'(x);
    x1e   = BW'(hist.x1);
    x2e   = BW'(hist.x2);
    x3e   = BW'(hist.x3);
    // times three as shift plus add
    binom = xe + x1e + (x1e <<< 1) + x2e + (x2e <<< 1) + x3e;

    p_gain  = coef.gain     * binom;
    p_one   = coef.fb_one   * hist.y1;
    p_two   = coef.fb_two   * hist.y2;
    p_three = coef.fb_three * hist.y3;

    acc = AW'(p_gain) + AW'(p_one) + AW'(p_two) + AW'(p_three) + rlp3_pkg::ROUND_HALF;

    // dropping the fraction bits is a floor shift
    shifted = acc[AW-1:rlp3_pkg::COEF_FRAC_BITS];

    fits = (shifted[SW-1:NW-1] == '0) || (shifted[SW-1:NW-1] == '1);
    clip = !fits;
    if (fits) begin
      y = shifted[NW-1:0];
    end else if (shifted[SW-1]) begin
      y = rlp3_pkg::SAMPLE_MIN;
    end else begin
      y = rlp3_pkg::SAMPLE_MAX;
    end
  end

endmodule

// ===== rtl/resonant_lowpass_third_order.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// s_axis   in         s_tvalid / s_tready    s_tdata: sample_in
// m_axis   out        m_tvalid / m_tready    m_tdata: sample_out, m_tuser: clipped
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data (coefficient write)
//
// One sample per cycle sustained while m_tready stays high. A sample passes an input
// register, then the filter arithmetic into the result register, before output valid.
// The rate is set by the feedback loop: four multiplies, the adder tree, rounding and
// saturation are all combinational so the new output can enter the history at once.
// Reset (rst, synchronous) clears coefficients, histories and both valid flags.
// A stall on m_tready holds the result and the input register; a new transaction is
// still taken while only the result waits.

module resonant_lowpass_third_order (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [rlp3_pkg::DATA_WIDTH-1:0]        s_tdata,   // [15:0] sample_in
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [rlp3_pkg::DATA_WIDTH-1:0]        m_tdata,   // [15:0] sample_out
  output logic [0:0]                             m_tuser,   // [0] clipped
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rlp3_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [rlp3_pkg::COEF_WIDTH-1:0]        cfg_data
);

  localparam int NW = rlp3_pkg::SAMPLE_WIDTH;

  rlp3_pkg::coef_t coef;
  rlp3_pkg::hist_t hist;

  logic                 in_valid;
  logic signed [NW-1:0] in_sample;
  logic signed [NW-1:0] y_calc;
  logic                 clip_calc;
  logic                 advance;
  logic                 in_take;
  logic signed [NW-1:0] out_sample;
  logic                 out_clip;

  assign cfg_ready = !rst;

  rlp3_coef_regs u_coef (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  rlp3_calc u_calc (
    .x    (in_sample),
    .hist (hist),
    .coef (coef),
    .y    (y_calc),
    .clip (clip_calc)
  );

  // Result register is free when empty or being drained this cycle.
  assign advance  = !m_tvalid || m_tready;
  // Input register takes a transaction when empty or moving forward.
  assign s_tready = !rst && (!in_valid || advance);
  assign in_take  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sample <= s_tdata[NW-1:0];
    end
  end

  // Advance histories exactly when a sample moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (in_valid && advance) begin
      hist.x3 <= hist.x2;
      hist.x2 <= hist.x1;
      hist.x1 <= in_sample;
      hist.y3 <= hist.y2;
      hist.y2 <= hist.y1;
      hist.y1 <= y_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_sample <= y_calc;
      out_clip   <= clip_calc;
    end
  end

  assign m_tdata = rlp3_pkg::DATA_WIDTH'($unsigned(out_sample));
  assign m_tuser = out_clip;

endmodule

// ===== rtl/rlp3_checker.sv =====
`timescale 1ns / 1ps

module rlp3_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rlp3_pkg::DATA_WIDTH-1:0]  m_tdata,
  input logic [0:0]                       m_tuser
);

  localparam int NW = rlp3_pkg::SAMPLE_WIDTH;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // input stalls only in reset or behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> rst || (m_tvalid && !m_tready))
    else $error("input stalled with room downstream");

  // a clipped result sits at a rail
  a_clip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (m_tdata[NW-1:0] == rlp3_pkg::SAMPLE_MAX) || (m_tdata[NW-1:0] == rlp3_pkg::SAMPLE_MIN))
    else $error("clipped result not saturated");

  // a fresh result follows an input transaction through the input and result registers
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching input transaction");

endmodule

bind resonant_lowpass_third_order rlp3_checker u_rlp3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
